[rtl/core/fsrc_pkg.sv]
package fsrc_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_VALUE    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NAK_VALUE    = 8'd3;

    // Register reset values
    localparam logic [BYTE_W-1:0] RST_START_MARKER = 8'h02;
    localparam logic [BYTE_W-1:0] RST_END_MARKER   = 8'h03;
    localparam logic [BYTE_W-1:0] RST_ACK_VALUE    = 8'h06;
    localparam logic [BYTE_W-1:0] RST_NAK_VALUE    = 8'h15;

    localparam logic [1:0] COUNT_MAX = 2'd3;
    localparam logic [1:0] COUNT_MIN_FRAME = 2'd2;

    // Running frame summary
    typedef struct packed {
        logic [BYTE_W-1:0] byte_sum;
        logic [BYTE_W-1:0] newest_byte;
        logic [BYTE_W-1:0] previous_byte;
        logic [1:0]        frame_count;
    } t_frame_state;

    // What one received byte does to the frame
    typedef struct packed {
        logic advance;
        logic is_start;
        logic is_end;
    } t_byte_ctrl;

    // ASCII hex digit decode: {is_digit, value}
    function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
        logic [4:0] res;
        res = 5'd0;
        case (c) inside
            [8'h30:8'h39]: res = {1'b1, c[3:0]};
            [8'h41:8'h46],
            [8'h61:8'h66]: res = {1'b1, c[3:0] + 4'd9};
            default:       res = 5'd0;
        endcase
        return res;
    endfunction

endpackage

[rtl/core/fsrc_if.sv]
interface fsrc_rx_if;
    import fsrc_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface fsrc_reply_if;
    import fsrc_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] reply_byte;
    logic              frame_good;
    modport source (output valid, output reply_byte, output frame_good, input ready);
    modport sink (input valid, input reply_byte, input frame_good, output ready);
endinterface

interface fsrc_cfg_if;
    import fsrc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/fsrc_frame_tracker.sv]
module fsrc_frame_tracker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fsrc_pkg::t_byte_ctrl  i_ctrl,
    input  logic [7:0]            i_byte,
    output logic                  o_good
);
    import fsrc_pkg::*;

    t_frame_state r_state;
    t_frame_state n_state;

    logic [4:0]        hi_dec;
    logic [4:0]        lo_dec;
    logic [BYTE_W-1:0] body_sum;

    always_comb begin
        n_state = r_state;
        if (i_ctrl.advance) begin
            if (i_ctrl.is_start) begin
                n_state = '0;
            end else if (!i_ctrl.is_end) begin
                n_state.byte_sum      = r_state.byte_sum + i_byte;
                n_state.previous_byte = r_state.newest_byte;
                n_state.newest_byte   = i_byte;
                if (r_state.frame_count != COUNT_MAX) begin
                    n_state.frame_count = r_state.frame_count + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    // Check the two trailing hex digits against the sum of the bytes before them
    always_comb begin
        hi_dec   = hex_decode(r_state.previous_byte);
        lo_dec   = hex_decode(r_state.newest_byte);
        body_sum = r_state.byte_sum - r_state.newest_byte - r_state.previous_byte;
        o_good   = (r_state.frame_count >= COUNT_MIN_FRAME) && hi_dec[4] && lo_dec[4]
                   && ({hi_dec[3:0], lo_dec[3:0]} == body_sum);
    end

endmodule

[rtl/core/framed_serial_receive_checker.sv]
// Framed serial receive checker.
//
// Channels: i_rx carries one received byte per request; o_reply carries one
// acknowledge/reject request (reply_byte, frame_good) for every end marker;
// i_cfg writes the start marker, end marker, ack and nak bytes (index 0..3,
// other indexes are ignored). i_cfg is always ready.
//
// Flow: a byte lands in the input register, is classified and folded into
// the frame summary on the next edge; an end marker's reply passes through the
// input register and then the result register before it shows on o_reply.
// Throughput: one byte per cycle while no end marker waits on an unclaimed
// reply; each byte updates the running sum and last-two-byte history.
//
// Reset (synchronous, active low): registers return to 2/3/6/21, the frame
// summary clears and both pipeline stages empty.
//
// Stall: while o_reply holds an unclaimed reply, bytes other than end markers
// keep flowing; an end marker waits in the input register and i_rx drops
// ready only then.
module framed_serial_receive_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fsrc_cfg_if.sink      i_cfg,
    fsrc_rx_if.sink       i_rx,
    fsrc_reply_if.source  o_reply
);
    import fsrc_pkg::*;

    // Configuration registers
    logic [BYTE_W-1:0] r_start_marker;
    logic [BYTE_W-1:0] r_end_marker;
    logic [BYTE_W-1:0] r_ack_value;
    logic [BYTE_W-1:0] r_nak_value;

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // Result register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_reply;
    logic              r_out_good;

    t_byte_ctrl ctrl;
    logic       frame_good;
    logic       in_take;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= RST_START_MARKER;
            r_end_marker   <= RST_END_MARKER;
            r_ack_value    <= RST_ACK_VALUE;
            r_nak_value    <= RST_NAK_VALUE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_START_MARKER: r_start_marker <= i_cfg.data;
                CFG_END_MARKER:   r_end_marker   <= i_cfg.data;
                CFG_ACK_VALUE:    r_ack_value    <= i_cfg.data;
                CFG_NAK_VALUE:    r_nak_value    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Classify the held byte; start wins when both markers match.
    // An end marker advances only if the result register can take its reply.
    always_comb begin
        ctrl.is_start = (r_in_byte == r_start_marker);
        ctrl.is_end   = !ctrl.is_start && (r_in_byte == r_end_marker);
        ctrl.advance  = r_in_valid && (!ctrl.is_end || !r_out_valid || o_reply.ready);
    end

    assign i_rx.ready = !r_in_valid || ctrl.advance;
    assign in_take    = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (ctrl.advance) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    fsrc_frame_tracker u_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_byte  (r_in_byte),
        .o_good  (frame_good)
    );

    // Load a reply on an advancing end marker; drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (ctrl.advance && ctrl.is_end) begin
                r_out_valid <= 1'b1;
            end else if (o_reply.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.advance && ctrl.is_end) begin
            r_out_reply <= frame_good ? r_ack_value : r_nak_value;
            r_out_good  <= frame_good;
        end
    end

    assign o_reply.valid      = r_out_valid;
    assign o_reply.reply_byte = r_out_reply;
    assign o_reply.frame_good = r_out_good;

endmodule

[tb/framed_serial_receive_checker_tb.sv]
import fsrc_pkg::*;

class frame_check_board;

    typedef struct packed {
        logic [BYTE_W-1:0] reply_byte;
        logic              frame_good;
    } reply_t;

    // register copies
    logic [BYTE_W-1:0] start_marker = RST_START_MARKER;
    logic [BYTE_W-1:0] end_marker   = RST_END_MARKER;
    logic [BYTE_W-1:0] ack_value    = RST_ACK_VALUE;
    logic [BYTE_W-1:0] nak_value    = RST_NAK_VALUE;

    // frame summary
    logic [BYTE_W-1:0] sum_acc   = '0;
    logic [BYTE_W-1:0] last_byte = '0;
    logic [BYTE_W-1:0] prior_byte = '0;
    logic [1:0]        appended  = '0;

    reply_t awaited_replies[$];
    int     fail_count = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
        case (idx)
            CFG_START_MARKER: start_marker = data;
            CFG_END_MARKER:   end_marker = data;
            CFG_ACK_VALUE:    ack_value = data;
            CFG_NAK_VALUE:    nak_value = data;
            default: ;
        endcase
    endfunction

    // {is_digit, value}; fold case by setting bit 5
    function logic [4:0] digit_of(logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] folded;
        folded = c | 8'h20;
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b1, c[3:0]};
        if (folded >= 8'h61 && folded <= 8'h66)
            return {1'b1, 4'(folded - 8'h57)};
        return 5'd0;
    endfunction

    function bit checksum_matches();
        logic [4:0]        hi;
        logic [4:0]        lo;
        logic [BYTE_W-1:0] body;
        if (appended < COUNT_MIN_FRAME)
            return 1'b0;
        hi = digit_of(prior_byte);
        lo = digit_of(last_byte);
        if (!hi[4] || !lo[4])
            return 1'b0;
        body = sum_acc - last_byte - prior_byte;
        return {hi[3:0], lo[3:0]} == body;
    endfunction

    function void note_rx_byte(logic [BYTE_W-1:0] b);
        reply_t r;
        bit     good;
        if (b == start_marker) begin
            sum_acc = '0;
            last_byte = '0;
            prior_byte = '0;
            appended = '0;
        end else if (b == end_marker) begin
            good = checksum_matches();
            r.reply_byte = good ? ack_value : nak_value;
            r.frame_good = good;
            awaited_replies.push_back(r);
        end else begin
            sum_acc = sum_acc + b;
            prior_byte = last_byte;
            last_byte = b;
            if (appended != COUNT_MAX)
                appended = appended + 2'd1;
        end
    endfunction

    function void report(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function void check_reply(logic [BYTE_W-1:0] reply_byte, logic frame_good);
        reply_t want;
        if (awaited_replies.size() == 0) begin
            report($sformatf("reply %02h good=%0b with none awaited", reply_byte, frame_good));
            return;
        end
        want = awaited_replies.pop_front();
        if (want.reply_byte !== reply_byte)
            report($sformatf("reply_byte expected %02h got %02h", want.reply_byte, reply_byte));
        if (want.frame_good !== frame_good)
            report($sformatf("frame_good expected %0b got %0b", want.frame_good, frame_good));
    endfunction

    function int pending_count();
        return awaited_replies.size();
    endfunction

endclass

module framed_serial_receive_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 6;
    // indexes the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX = 8'hFF;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fsrc_cfg_if   cfg_ch();
    fsrc_rx_if    rx_ch();
    fsrc_reply_if reply_ch();

    framed_serial_receive_checker u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_rx    (rx_ch),
        .o_reply (reply_ch)
    );

    frame_check_board board = new();

    bit calm = 1'b0;      // when set, neither side idles
    bit hold_req = 1'b0;  // ask the reply side for one long hold-off
    int items_sent = 0;

    // directed bytes, reset markers: start 02, end 03
    logic [7:0] directed_bytes [25] = '{
        8'h03,                              // end on an empty frame: nak
        8'h02, 8'h30, 8'h03,                // one-byte frame: nak
        8'h02, 8'h30, 8'h30, 8'h03,         // empty body, checksum "00": ack
        8'h03,                              // repeated end rechecks: ack
        8'h02, 8'hFF, 8'h00, 8'h46, 8'h46, 8'h03, // body FF 00, "FF": ack
        8'h02, 8'h47, 8'h31, 8'h03,         // 'G' is not hex: nak
        8'h02, 8'h0A, 8'h30, 8'h61, 8'h03,  // lowercase "0a": ack
        8'h46                               // appended after an end: no reply
    };

    always #10 i_clk = ~i_clk;

    // Pick an idle length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one byte, hold it until the block takes the request, then note it.
    task automatic send_rx(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            rx_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        board.note_rx_byte(b);
        items_sent++;
    endtask

    task automatic rx_idle();
        @(negedge i_clk);
        rx_ch.valid <= 1'b0;
    endtask

    // Write one register; valid stays up so back-to-back writes never glitch.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.write_reg(idx, data);
    endtask

    // Wait for every awaited reply, then let in-flight bytes settle.
    task automatic drain();
        while (board.pending_count() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + n;
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + (n - 4'd10);
    endfunction

    // Body byte that is neither marker.
    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == board.start_marker || b == board.end_marker);
        return b;
    endfunction

    // Mostly well-formed frames with random content; the rest noise and broken frames.
    task automatic send_random_frame();
        int         kind;
        int         len;
        logic [7:0] sum;
        logic [7:0] carried;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            // noise, markers included often
            repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(0, 9))
                    0: b = board.start_marker;
                    1: b = board.end_marker;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_rx(b);
            end
        end else begin
            if (kind >= 25)
                send_rx(board.start_marker);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
            sum = '0;
            repeat (len) begin
                b = body_byte();
                sum = sum + b;
                send_rx(b);
            end
            carried = sum;
            if ($urandom_range(0, 6) == 0)
                carried = sum + 8'($urandom_range(1, 255));
            // occasionally break one checksum digit
            if ($urandom_range(0, 11) == 0)
                send_rx(body_byte());
            else
                send_rx(hex_char(carried[7:4]));
            if ($urandom_range(0, 11) == 0)
                send_rx(body_byte());
            else
                send_rx(hex_char(carried[3:0]));
            send_rx(board.end_marker);
            if ($urandom_range(0, 99) < 15)
                send_rx(board.end_marker);
            if ($urandom_range(0, 99) < 10)
                repeat ($urandom_range(1, 3)) send_rx(body_byte());
        end
    endtask

    // One setting of the four registers followed by random frames.
    task automatic run_phase(input logic [7:0] start_mk, input logic [7:0] end_mk,
                             input logic [7:0] ack, input logic [7:0] nak,
                             input int n_items, input bit with_hold);
        int stop_at;
        bit held;
        drain();
        write_reg(CFG_START_MARKER, start_mk);
        write_reg(CFG_END_MARKER, end_mk);
        write_reg(CFG_ACK_VALUE, ack);
        write_reg(CFG_NAK_VALUE, nak);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        stop_at = items_sent + n_items;
        held = 1'b0;
        while (items_sent < stop_at) begin
            if (with_hold && !held && items_sent > stop_at - n_items + 40) begin
                // push hard while the reply side holds off
                calm = 1'b1;
                hold_req = 1'b1;
                held = 1'b1;
            end else if ($urandom_range(0, 19) == 0) begin
                calm = !calm;
            end
            send_random_frame();
        end
        rx_idle();
        calm = 1'b0;
    endtask

    // Reply side: stall at random, honor one long hold-off, check every request taken.
    initial begin
        int stall_left;
        stall_left = 0;
        reply_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                reply_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                reply_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                reply_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
            @(posedge i_clk);
            if (reply_ch.valid && reply_ch.ready)
                board.check_reply(reply_ch.reply_byte, reply_ch.frame_good);
        end
    end

    // Main sequence.
    initial begin
        int         guard;
        int         leftover;
        logic [7:0] s;
        logic [7:0] e;
        i_rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset register values
        foreach (directed_bytes[k])
            send_rx(directed_bytes[k]);
        rx_idle();

        run_phase(RST_START_MARKER, RST_END_MARKER, RST_ACK_VALUE, RST_NAK_VALUE, 200, 1'b0);

        // ignored indexes must leave the registers alone
        drain();
        write_reg(CFG_UNUSED_IDX, 8'hAA);
        write_reg(CFG_TOP_IDX, 8'h55);
        run_phase(8'h00, 8'hFF, 8'hFF, 8'h00, 220, 1'b0);

        // start equal to end, both a hex digit: every such byte restarts the frame
        run_phase(8'h30, 8'h30, 8'h80, 8'h7F, 80, 1'b0);

        s = 8'($urandom_range(0, 255));
        do e = 8'($urandom_range(0, 255)); while (e == s);
        run_phase(s, e, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 250, 1'b1);

        run_phase(8'hFF, 8'h00, 8'h00, 8'hFF, 220, 1'b0);

        s = 8'($urandom_range(0, 255));
        do e = 8'($urandom_range(0, 255)); while (e == s);
        run_phase(s, e, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 200, 1'b0);

        // wait out the last replies, bounded
        guard = 0;
        while (board.pending_count() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        leftover = board.pending_count();
        if (leftover != 0)
            $display("%0d replies never arrived", leftover);

        if (board.fail_count == 0 && leftover == 0)
            $display("** framed_serial_receive_checker: PASSED **");
        else
            $display("** framed_serial_receive_checker: FAILED **");
        $finish;
    end

    // hard stop
    initial begin
        #10_000_000;
        $display("** framed_serial_receive_checker: FAILED **");
        $finish;
    end

endmodule
